// ----- sv/mwe_pkg.sv -----
// mwe_pkg: shared constants, codes and tables of the network evaluator
// no dependencies; imported by mlp_wavefunction_eval_top
package mwe_pkg;

    localparam int HIDDEN_UNITS = 16;
    localparam int FEATURES     = 3;
    localparam int NUM_SLOTS    = FEATURES + 2;
    localparam int NUM_WORDS    = NUM_SLOTS * HIDDEN_UNITS;
    localparam int WADDR_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int UNIT_W       = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;

    // item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    // weight slots past the feature weights
    localparam logic [2:0] SLOT_BIAS = 3'(FEATURES);
    localparam logic [2:0] SLOT_OUT  = 3'(FEATURES + 1);

    localparam logic [30:0] S3_Q30  = 31'd1859775393;
    localparam logic [30:0] L2E_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30 = 30'd744261118;
    localparam logic [22:0] FEAT_MAX = 23'd8388607;
    localparam logic [3:0]  TAYLOR_TERMS = 4'd12;

    // exact floor(v / n) for v < 2^31: (v * m) >> sh
    function automatic logic [31:0] recip_mul(input logic [3:0] n);
        logic [31:0] m;
        begin
            case (n)
                4'd3, 4'd6, 4'd12: m = 32'd2863311531;
                4'd5, 4'd10:       m = 32'd3435973837;
                4'd7:              m = 32'd2454267027;
                4'd9:              m = 32'd3817748708;
                4'd11:             m = 32'd3123612579;
                default:           m = 32'd2147483648;
            endcase
            return m;
        end
    endfunction

    function automatic logic [5:0] recip_shift(input logic [3:0] n);
        logic [5:0] s;
        begin
            case (n)
                4'd1:                      s = 6'd31;
                4'd2:                      s = 6'd32;
                4'd3, 4'd4:                s = 6'd33;
                4'd5, 4'd6, 4'd7, 4'd8:    s = 6'd34;
                default:                   s = 6'd35;
            endcase
            return s;
        end
    endfunction

endpackage

// ----- sv/mwe_ram.sv -----
// mwe_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module mwe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 80,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/mlp_wavefunction_eval_top.sv -----
// mlp_wavefunction_eval_top: one-hidden-layer tanh network with exp output
// depends on mwe_pkg and mwe_ram
//
// A load item (tuser = 0) writes one signed Q8.16 weight and gives no result;
// the weight store reads as zero after reset until written. An evaluate item
// (tuser = 1) forms the three distance features, runs every hidden unit
// through bias plus weighted features, tanh and the output weight, and returns
// exp of the sum as unsigned Q16.16 with a saturation flag. All multiplies go
// through a single 33x33 multiplier under a sequencer, and the input is not
// ready while an item is at work: the work of an evaluate item is set mostly
// by the 12-term exp series of each tanh, two multiplies per term, and the
// 17-step divide of tanh, and is shorter when a hidden unit saturates its tanh.
// A finished result waits in the output register while the next item is taken.
module mlp_wavefunction_eval_top
    import mwe_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // unit_index, weight_slot, weight_value, vec_a_x, vec_a_y, vec_a_z,
    // vec_b_x, vec_b_y, vec_b_z, one zero pad bit
    input  logic [175:0] s_axis_tdata,
    // kind
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // amplitude
    output logic [31:0]  m_axis_tdata,
    // saturated
    output logic [0:0]   m_axis_tuser
);

    typedef enum logic [4:0] {
        S_IDLE, S_WAIT, S_F0, S_F1, S_F2, S_F3, S_F4, S_SQ_INIT, S_SQ_STEP,
        S_HB, S_HM, S_HA, S_T0, S_E0, S_E1, S_E2, S_E3, S_E4,
        S_TDIV_INIT, S_TDIV, S_OM, S_OA, S_FIN, S_OUT, S_DONE
    } t_state;

    typedef enum logic {EXP_TANH, EXP_OUT} t_emode;

    t_state r_state, r_ret;
    t_emode r_emode;

    // input fields
    logic [3:0]         in_unit;
    logic [2:0]         in_slot;
    logic [23:0]        in_weight;
    logic               in_kind;
    logic               load_we;
    logic [31:0]        waddr_full, raddr_full;
    logic [WADDR_W-1:0] waddr, raddr;

    // vectors and features
    logic signed [23:0] r_a [0:2];
    logic signed [23:0] r_b [0:2];
    logic [1:0]         r_idx;
    logic [51:0]        r_sq0, r_sq1, r_sq2;
    logic signed [26:0] r_pq;
    logic [22:0]        r_feat [0:2];

    // square root
    logic [51:0] r_sv, r_sres, r_sbit;
    logic [51:0] sq_sum, sq_sel, feat_raw;
    logic        sq_ge;
    logic [22:0] feat_val;

    // shared multiplier
    logic signed [32:0] r_ma, r_mb;
    logic signed [65:0] r_prod;

    // weight store
    logic [NUM_WORDS-1:0] r_wvalid;
    logic                 r_rvld;
    logic [23:0]          ram_q;
    logic signed [23:0]   w_cur;
    logic [2:0]           r_slot;
    logic [UNIT_W-1:0]    r_unit;

    // hidden layer and output sum
    logic signed [51:0] r_h, r_acc, h_rnd, acc_rnd;
    logic signed [35:0] u_val, s_val;
    logic [35:0]        t_abs;
    logic               r_neg;
    logic [16:0]        r_mag;
    logic signed [17:0] th_val;
    logic signed [23:0] a_cur, b_cur;
    logic signed [59:0] prod60, b_sh, p_sum, q_sum;
    logic signed [26:0] p_val, q_val;
    logic [22:0]        feat_cur;

    // exp unit
    logic signed [21:0] r_ex;
    logic signed [6:0]  r_ek;
    logic [29:0]        r_ez;
    logic [31:0]        r_esum;
    logic [3:0]         r_en;
    logic [62:0]        prod63;
    logic [30:0]        term_new;

    // divider
    logic [54:0] r_dd, r_dr;
    logic [16:0] r_dn, r_dq;
    logic [4:0]  r_dcnt;
    logic [54:0] d_val, n_val;
    logic [55:0] div_try;
    logic        div_ge;

    // output scaling
    logic signed [7:0] out_sh;
    logic [5:0]        out_rs;
    logic [63:0]       out_val;
    logic [31:0]       r_amp;
    logic              r_sat;

    logic        r_out_valid;
    logic [31:0] r_out_amp;
    logic        r_out_sat;

    assign in_unit   = s_axis_tdata[3:0];
    assign in_slot   = s_axis_tdata[6:4];
    assign in_weight = s_axis_tdata[30:7];
    assign in_kind   = s_axis_tuser[0];

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_amp;
    assign m_axis_tuser  = r_out_sat;

    assign load_we = s_axis_tvalid && s_axis_tready && (in_kind == KIND_LOAD)
                     && (32'(in_unit) < 32'(HIDDEN_UNITS)) && (in_slot < 3'(NUM_SLOTS));
    assign waddr_full = 32'(in_slot) * 32'(HIDDEN_UNITS) + 32'(in_unit);
    assign raddr_full = 32'(r_slot) * 32'(HIDDEN_UNITS) + 32'(r_unit);
    assign waddr = waddr_full[WADDR_W-1:0];
    assign raddr = raddr_full[WADDR_W-1:0];

    mwe_ram #(
        .WIDTH(24),
        .DEPTH(NUM_WORDS)
    ) u_wram (
        .i_clk  (i_clk),
        .i_we   (load_we),
        .i_waddr(waddr),
        .i_wdata(in_weight),
        .i_raddr(raddr),
        .o_rdata(ram_q)
    );

    always_comb begin
        // entries never written read as zero
        w_cur = r_rvld ? $signed(ram_q) : 24'sd0;

        case (r_idx)
            2'd0:    begin a_cur = r_a[0]; b_cur = r_b[0]; sq_sel = r_sq0; end
            2'd1:    begin a_cur = r_a[1]; b_cur = r_b[1]; sq_sel = r_sq1; end
            default: begin a_cur = r_a[2]; b_cur = r_b[2]; sq_sel = r_sq2; end
        endcase

        case (r_slot)
            3'd0:    feat_cur = r_feat[0];
            3'd1:    feat_cur = r_feat[1];
            default: feat_cur = r_feat[2];
        endcase

        // p, q = round((a*sqrt3 +/- b) , 30) with product already in r_prod
        prod60 = r_prod[59:0];
        b_sh   = {{6{b_cur[23]}}, b_cur, 30'd0};
        p_sum  = prod60 + b_sh + 60'sd536870912;
        q_sum  = prod60 - b_sh + 60'sd536870912;
        p_val  = p_sum[56:30];
        q_val  = q_sum[56:30];

        sq_sum   = r_sres + r_sbit;
        sq_ge    = (r_sv >= sq_sum);
        feat_raw = (r_idx == 2'd0) ? r_sres : ((r_sres + 52'd1) >> 1);
        feat_val = (feat_raw > 52'(FEAT_MAX)) ? FEAT_MAX : feat_raw[22:0];

        h_rnd = r_h + 52'sd32768;
        u_val = h_rnd[51:16];
        t_abs = u_val[35] ? 36'(-u_val) : 36'(u_val);

        acc_rnd = r_acc + 52'sd32768;
        s_val   = acc_rnd[51:16];

        th_val = r_neg ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});

        prod63   = r_prod[62:0];
        term_new = 31'(prod63 >> recip_shift(r_en));

        d_val   = (55'(r_esum) << r_ek[4:0]) + 55'd1073741824;
        n_val   = 55'd140737488355328 + (d_val >> 1);
        div_try = {r_dr, r_dn[16]};
        div_ge  = (div_try >= {1'b0, r_dd});

        out_sh = $signed({r_ek[6], r_ek}) - 8'sd14;
        out_rs = 6'(-out_sh);
        if (!out_sh[7]) begin
            out_val = 64'(r_esum) << out_sh[3:0];
        end else begin
            out_val = (64'(r_esum) + (64'd1 << (out_rs - 6'd1))) >> out_rs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_emode     <= EXP_TANH;
            r_out_valid <= 1'b0;
            r_wvalid    <= '0;
            r_slot      <= 3'd0;
            r_unit      <= '0;
            r_idx       <= 2'd0;
            r_rvld      <= 1'b0;
        end else begin
            // a new result in the done state takes the register itself
            if (r_out_valid && m_axis_tready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            r_prod <= r_ma * r_mb;
            r_rvld <= r_wvalid[raddr];
            if (load_we) begin
                r_wvalid[waddr] <= 1'b1;
            end

            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && in_kind == KIND_EVAL) begin
                        r_a[0] <= s_axis_tdata[54:31];
                        r_a[1] <= s_axis_tdata[78:55];
                        r_a[2] <= s_axis_tdata[102:79];
                        r_b[0] <= s_axis_tdata[126:103];
                        r_b[1] <= s_axis_tdata[150:127];
                        r_b[2] <= s_axis_tdata[174:151];
                        r_idx  <= 2'd0;
                        r_sq0  <= '0;
                        r_sq1  <= '0;
                        r_sq2  <= '0;
                        r_state <= S_F0;
                    end
                end
                S_WAIT: begin
                    // multiplier product and ram read both land here
                    r_state <= r_ret;
                end
                S_F0: begin
                    r_ma    <= 33'(b_cur);
                    r_mb    <= 33'(b_cur);
                    r_ret   <= S_F1;
                    r_state <= S_WAIT;
                end
                S_F1: begin
                    r_sq0   <= r_sq0 + r_prod[51:0];
                    r_ma    <= 33'(a_cur);
                    r_mb    <= {2'b00, S3_Q30};
                    r_ret   <= S_F2;
                    r_state <= S_WAIT;
                end
                S_F2: begin
                    r_pq    <= q_val;
                    r_ma    <= 33'(p_val);
                    r_mb    <= 33'(p_val);
                    r_ret   <= S_F3;
                    r_state <= S_WAIT;
                end
                S_F3: begin
                    r_sq1   <= r_sq1 + r_prod[51:0];
                    r_ma    <= 33'(r_pq);
                    r_mb    <= 33'(r_pq);
                    r_ret   <= S_F4;
                    r_state <= S_WAIT;
                end
                S_F4: begin
                    r_sq2 <= r_sq2 + r_prod[51:0];
                    if (r_idx == 2'd2) begin
                        r_idx   <= 2'd0;
                        r_state <= S_SQ_INIT;
                    end else begin
                        r_idx   <= r_idx + 2'd1;
                        r_state <= S_F0;
                    end
                end
                S_SQ_INIT: begin
                    r_sv    <= sq_sel;
                    r_sres  <= '0;
                    r_sbit  <= 52'd1 << 50;
                    r_state <= S_SQ_STEP;
                end
                S_SQ_STEP: begin
                    if (r_sbit == '0) begin
                        case (r_idx)
                            2'd0:    r_feat[0] <= feat_val;
                            2'd1:    r_feat[1] <= feat_val;
                            default: r_feat[2] <= feat_val;
                        endcase
                        if (r_idx == 2'd2) begin
                            r_unit  <= '0;
                            r_slot  <= SLOT_BIAS;
                            r_acc   <= '0;
                            r_ret   <= S_HB;
                            r_state <= S_WAIT;
                        end else begin
                            r_idx   <= r_idx + 2'd1;
                            r_state <= S_SQ_INIT;
                        end
                    end else begin
                        if (sq_ge) begin
                            r_sv   <= r_sv - sq_sum;
                            r_sres <= (r_sres >> 1) + r_sbit;
                        end else begin
                            r_sres <= r_sres >> 1;
                        end
                        r_sbit <= r_sbit >> 2;
                    end
                end
                S_HB: begin
                    r_h     <= {{12{w_cur[23]}}, w_cur, 16'd0};
                    r_slot  <= 3'd0;
                    r_ret   <= S_HM;
                    r_state <= S_WAIT;
                end
                S_HM: begin
                    r_ma    <= 33'(w_cur);
                    r_mb    <= {10'd0, feat_cur};
                    r_ret   <= S_HA;
                    r_state <= S_WAIT;
                end
                S_HA: begin
                    r_h <= r_h + $signed(r_prod[51:0]);
                    if (r_slot == 3'(FEATURES - 1)) begin
                        r_state <= S_T0;
                    end else begin
                        r_slot  <= r_slot + 3'd1;
                        r_ret   <= S_HM;
                        r_state <= S_WAIT;
                    end
                end
                S_T0: begin
                    r_neg <= u_val[35];
                    if (t_abs >= 36'd524288) begin
                        r_mag   <= 17'd65536;
                        r_slot  <= SLOT_OUT;
                        r_ret   <= S_OM;
                        r_state <= S_WAIT;
                    end else begin
                        r_ex    <= {2'b00, t_abs[18:0], 1'b0};
                        r_emode <= EXP_TANH;
                        r_state <= S_E0;
                    end
                end
                S_E0: begin
                    r_ma    <= 33'(r_ex);
                    r_mb    <= {2'b00, L2E_Q30};
                    r_ret   <= S_E1;
                    r_state <= S_WAIT;
                end
                S_E1: begin
                    // integer part of the base-2 exponent and its fraction
                    r_ek    <= r_prod[52:46];
                    r_ma    <= {3'b000, r_prod[45:16]};
                    r_mb    <= {3'b000, LN2_Q30};
                    r_ret   <= S_E2;
                    r_state <= S_WAIT;
                end
                S_E2: begin
                    r_ez    <= r_prod[59:30];
                    r_esum  <= 32'd1073741824;
                    r_en    <= 4'd1;
                    r_ma    <= 33'd1073741824;
                    r_mb    <= {3'b000, r_prod[59:30]};
                    r_ret   <= S_E3;
                    r_state <= S_WAIT;
                end
                S_E3: begin
                    r_ma    <= {2'b00, r_prod[60:30]};
                    r_mb    <= {1'b0, recip_mul(r_en)};
                    r_ret   <= S_E4;
                    r_state <= S_WAIT;
                end
                S_E4: begin
                    r_esum <= r_esum + 32'(term_new);
                    if (r_en == TAYLOR_TERMS) begin
                        r_state <= (r_emode == EXP_TANH) ? S_TDIV_INIT : S_OUT;
                    end else begin
                        r_en    <= r_en + 4'd1;
                        r_ma    <= {2'b00, term_new};
                        r_mb    <= {3'b000, r_ez};
                        r_ret   <= S_E3;
                        r_state <= S_WAIT;
                    end
                end
                S_TDIV_INIT: begin
                    r_dd    <= d_val;
                    r_dr    <= 55'(n_val[54:17]);
                    r_dn    <= n_val[16:0];
                    r_dq    <= '0;
                    r_dcnt  <= 5'd17;
                    r_state <= S_TDIV;
                end
                S_TDIV: begin
                    if (r_dcnt == 5'd0) begin
                        r_mag   <= 17'd65536 - r_dq;
                        r_slot  <= SLOT_OUT;
                        r_ret   <= S_OM;
                        r_state <= S_WAIT;
                    end else begin
                        if (div_ge) begin
                            r_dr <= 55'(div_try - {1'b0, r_dd});
                        end else begin
                            r_dr <= div_try[54:0];
                        end
                        r_dq   <= {r_dq[15:0], div_ge};
                        r_dn   <= {r_dn[15:0], 1'b0};
                        r_dcnt <= r_dcnt - 5'd1;
                    end
                end
                S_OM: begin
                    r_ma    <= 33'(w_cur);
                    r_mb    <= 33'(th_val);
                    r_ret   <= S_OA;
                    r_state <= S_WAIT;
                end
                S_OA: begin
                    r_acc <= r_acc + $signed(r_prod[51:0]);
                    if (r_unit == UNIT_W'(HIDDEN_UNITS - 1)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_unit  <= r_unit + 1'b1;
                        r_slot  <= SLOT_BIAS;
                        r_ret   <= S_HB;
                        r_state <= S_WAIT;
                    end
                end
                S_FIN: begin
                    if (s_val >= 36'sd1048576) begin
                        r_amp   <= 32'hFFFF_FFFF;
                        r_sat   <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        // very negative sums are taken at -32.0
                        r_ex    <= (s_val < -36'sd2097152) ? -22'sd2097152 : s_val[21:0];
                        r_emode <= EXP_OUT;
                        r_state <= S_E0;
                    end
                end
                S_OUT: begin
                    if (out_val[63:32] != 32'd0) begin
                        r_amp <= 32'hFFFF_FFFF;
                        r_sat <= 1'b1;
                    end else begin
                        r_amp <= out_val[31:0];
                        r_sat <= 1'b0;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_amp   <= r_amp;
                        r_out_sat   <= r_sat;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
